// ===== design/sorted_key_list_insert_delete_defines.svh =====
// ============================================================================
// Assertion macros for the sorted key store
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ============================================================================
`ifndef SORTED_KEY_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_KEY_LIST_INSERT_DELETE_DEFINES_SVH

// The condition must hold at every clock edge out of reset.
`define SKL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define SKL_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/skl_pkg.sv =====
// ============================================================================
// Sorted key store package
// Field widths, result codes and the command and status bundles that join
// the controller to the datapath.
// ============================================================================
package skl_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation selected by the mode field.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Read address selection, relative to the working index.
    localparam logic [1:0] RD_PREV = 2'd0;
    localparam logic [1:0] RD_CUR  = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    typedef struct packed {
        logic                load;
        logic                load_ins;
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                wr_en;
        logic                wr_key;
        logic                idx_inc;
        logic                idx_dec;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } skl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic idx_zero;
        logic idx_at_end;
        logic idx_last;
        logic rd_less;
        logic rd_equal;
        logic out_free;
    } skl_stat_t;

endpackage

// ===== design/skl_dpath.sv =====
// ============================================================================
// Sorted key store datapath
// Key memory, working index, entry count, smallest-key copy and the result
// register that drives the output channel.
// ============================================================================
`include "sorted_key_list_insert_delete_defines.svh"

module skl_dpath
    import skl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  skl_cmd_t                   cmd,
    output skl_stat_t                  stat,
    input  logic signed [KEY_W-1:0]    in_key,
    input  logic                       out_ready,
    output logic                       res_valid,
    output logic [STATUS_W-1:0]        res_status,
    output logic [COUNT_W-1:0]         res_count,
    output logic signed [KEY_W-1:0]    res_smallest,
    output logic                       res_smallest_valid
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] mem [CAPACITY];

    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           idx_prev, idx_succ;
    logic [AW-1:0]           rd_addr, wr_addr;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] rd_data_reg;
    logic signed [KEY_W-1:0] smallest_reg;
    logic signed [KEY_W-1:0] wr_data;
    logic [COUNT_W-1:0]      count_port;
    logic                    res_valid_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic [COUNT_W-1:0]      res_count_reg;
    logic signed [KEY_W-1:0] res_smallest_reg;
    logic                    res_smallest_valid_reg;

    assign idx_prev = idx_reg - CW'(1);
    assign idx_succ = idx_reg + CW'(1);
    assign wr_addr  = idx_reg[AW-1:0];
    assign wr_data  = cmd.wr_key ? key_reg : rd_data_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PREV: rd_addr = idx_prev[AW-1:0];
            RD_CUR:  rd_addr = idx_reg[AW-1:0];
            RD_NEXT: rd_addr = idx_succ[AW-1:0];
            default: rd_addr = idx_reg[AW-1:0];
        endcase
    end

    // Key memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entry 0 is mirrored so the smallest key is always at hand.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_key;
        end
        if (cmd.wr_en && (wr_addr == '0))
        begin
            smallest_reg <= wr_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = cmd.load_ins ? count_reg : '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_succ;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    generate
        if (CW >= COUNT_W)
        begin : g_count_trunc
            assign count_port = count_reg[COUNT_W-1:0];
        end
        else
        begin : g_count_ext
            assign count_port = {{(COUNT_W - CW){1'b0}}, count_reg};
        end
    endgenerate

    // Result register; a new result may load in the cycle the old one leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg         <= cmd.res_status;
            res_count_reg          <= count_port;
            res_smallest_reg       <= (count_reg != '0) ? smallest_reg : '0;
            res_smallest_valid_reg <= (count_reg != '0);
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg == CW'(CAPACITY));
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.idx_at_end = (idx_reg == count_reg);
    assign stat.idx_last   = (idx_succ == count_reg);
    assign stat.rd_less    = (rd_data_reg < key_reg);
    assign stat.rd_equal   = (rd_data_reg == key_reg);
    assign stat.out_free   = !res_valid_reg || out_ready;

    assign res_valid          = res_valid_reg;
    assign res_status         = res_status_reg;
    assign res_count          = res_count_reg;
    assign res_smallest       = res_smallest_reg;
    assign res_smallest_valid = res_smallest_valid_reg;

    `SKL_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `SKL_ASSERT_IMPLY(a_inc_not_full, cmd.cnt_inc, !stat.count_full, "insert into full store")
    `SKL_ASSERT_IMPLY(a_dec_not_empty, cmd.cnt_dec, !stat.count_zero, "delete from empty store")
    `SKL_ASSERT_IMPLY(a_res_no_overrun, cmd.res_load, stat.out_free, "result overwritten")

endmodule

// ===== design/skl_ctrl.sv =====
// ============================================================================
// Sorted key store controller
// Sequences the scan and shift steps of one insert or delete and hands the
// finished status to the result register.
// ============================================================================
module skl_ctrl
    import skl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_mode,
    output logic       in_ready,
    input  skl_stat_t  stat,
    output skl_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_CHECK = 3'd1;
    localparam logic [2:0] S_INS_WAIT  = 3'd2;
    localparam logic [2:0] S_DEL_CHECK = 3'd3;
    localparam logic [2:0] S_DEL_WAIT  = 3'd4;
    localparam logic [2:0] S_SHF_CHECK = 3'd5;
    localparam logic [2:0] S_SHF_WAIT  = 3'd6;
    localparam logic [2:0] S_RESULT    = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] pend_reg, pend_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == MODE_INSERT)
                    begin
                        if (stat.count_full)
                        begin
                            pend_next  = ST_FULL;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.load     = 1'b1;
                            cmd.load_ins = 1'b1;
                            state_next   = S_INS_CHECK;
                        end
                    end
                    else
                    begin
                        if (stat.count_zero)
                        begin
                            pend_next  = ST_EMPTY;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_DEL_CHECK;
                        end
                    end
                end
            end
            // Walk down from the top, moving up every key not below the new one.
            S_INS_CHECK:
            begin
                if (stat.idx_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    pend_next   = ST_DONE;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                    state_next = S_INS_WAIT;
                end
            end
            S_INS_WAIT:
            begin
                cmd.wr_en = 1'b1;
                if (stat.rd_less)
                begin
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    pend_next   = ST_DONE;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_INS_CHECK;
                end
            end
            // Walk up from the bottom to the first key not below the target.
            S_DEL_CHECK:
            begin
                if (stat.idx_at_end)
                begin
                    pend_next  = ST_NOT_FOUND;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_DEL_WAIT;
                end
            end
            S_DEL_WAIT:
            begin
                if (stat.rd_less)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_DEL_CHECK;
                end
                else if (stat.rd_equal)
                begin
                    state_next = S_SHF_CHECK;
                end
                else
                begin
                    pend_next  = ST_NOT_FOUND;
                    state_next = S_RESULT;
                end
            end
            // Close the gap by moving every later key down one place.
            S_SHF_CHECK:
            begin
                if (stat.idx_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    pend_next   = ST_DONE;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_SHF_WAIT;
                end
            end
            S_SHF_WAIT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_SHF_CHECK;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ===== design/sorted_key_list_insert_delete.sv =====
// ============================================================================
// Sorted key store with insert and delete
// Keeps up to CAPACITY signed 32-bit keys in ascending order and answers each
// insert or delete item with one result item.
// ============================================================================
// Usage: each item on the slave channel carries a key in s_tdata and the
// operation in s_tuser (0 inserts the key, 1 deletes one equal key). Every
// item produces exactly one result item on the master channel with the
// status, the entry count after the operation and the smallest key held.
// The keys live in a single-port-write, registered-read memory, so one
// item costs one scan step per key it passes over, and each step is a
// read followed by a decide-and-write state. A rejected insert or a delete
// on an empty store goes straight to the result with no scan.
// One item is worked on at a time; s_tready is high only while the block is
// idle. The finished result sits in an output register, so a new item is
// accepted as soon as the result has been loaded even if it is not taken.
// If the receiver stalls, the next result waits in the controller until the
// output register frees up. Reset empties the store at once, with no sweep.
// ============================================================================
module sorted_key_list_insert_delete
    import skl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [6:2] entry_count,
                                   // [38:7] smallest_key, [39] smallest_valid
);

    skl_cmd_t                cmd;
    skl_stat_t               stat;
    logic [STATUS_W-1:0]     res_status;
    logic [COUNT_W-1:0]      res_count;
    logic signed [KEY_W-1:0] res_smallest;
    logic                    res_smallest_valid;

    // The controller decides each step from the datapath's compare flags.
    skl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the key memory and the result register.
    skl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .in_key             ($signed(s_tdata)),
        .out_ready          (m_tready),
        .res_valid          (m_tvalid),
        .res_status         (res_status),
        .res_count          (res_count),
        .res_smallest       (res_smallest),
        .res_smallest_valid (res_smallest_valid)
    );

    assign m_tdata = {res_smallest_valid, res_smallest, res_count, res_status};

endmodule
